FILE: design/whdp_pkg.sv
// Package for the RIFF/WAVE header duration parser.
// Holds the channel payload types, the controller/datapath link types and constants.
// No dependencies.
`timescale 1ns / 1ps
package whdp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } whdp_in_t;

  typedef struct packed {
    logic        is_pcm;
    logic [41:0] duration_ms;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
  } whdp_out_t;

  typedef struct packed {
    logic accept;
    logic mul_frame;
    logic mul_lo;
    logic mul_hi;
    logic div_step;
    logic vor_load;
    logic out_load;
    logic clear;
  } whdp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic vor_ok;
  } whdp_stat_t;

  localparam logic [31:0] ID_FMT  = 32'h2074_6d66;
  localparam logic [31:0] ID_DATA = 32'h6174_6164;
  localparam logic [15:0] TAG_PCM = 16'h0001;
  localparam logic [15:0] TAG_EXT = 16'hfffe;
  localparam logic [15:0] TAG_VOR = 16'hffff;
  localparam logic [31:0] VOR_MIN_SIZE = 32'h0000_001c;
  localparam logic [41:0] MS_PER_SEC = 42'd1000;
  localparam int DIV_STEPS = 42;
  localparam logic [4:0] MIN_FILE_SIZE = 5'd20;

  function automatic logic [7:0] riff_mark(input logic [1:0] idx);
    unique case (idx)
      2'd0: riff_mark = 8'h52;
      2'd1: riff_mark = 8'h49;
      2'd2: riff_mark = 8'h46;
      default: riff_mark = 8'h46;
    endcase
  endfunction

  function automatic logic [7:0] wave_mark(input logic [1:0] idx);
    unique case (idx)
      2'd0: wave_mark = 8'h57;
      2'd1: wave_mark = 8'h41;
      2'd2: wave_mark = 8'h56;
      default: wave_mark = 8'h45;
    endcase
  endfunction

endpackage

FILE: design/whdp_ctrl.sv
// Controller of the RIFF/WAVE header duration parser.
// Sequences byte intake, the duration multiplies, the serial divides and the result load.
// Depends on whdp_pkg.
`timescale 1ns / 1ps
module whdp_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_stall,
  input  whdp_pkg::whdp_stat_t stat,
  output whdp_pkg::whdp_cmd_t  cmd
);
  import whdp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PM0  = 3'd1;
  localparam logic [2:0] S_PM1  = 3'd2;
  localparam logic [2:0] S_PM2  = 3'd3;
  localparam logic [2:0] S_PDIV = 3'd4;
  localparam logic [2:0] S_VCHK = 3'd5;
  localparam logic [2:0] S_VDIV = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       cnt_end;

  assign in_stall = (state_r != S_IDLE);
  assign cnt_end  = (cnt_r == 6'(DIV_STEPS - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_last) begin
            state_nxt = S_PM0;
          end
        end
      end
      S_PM0: begin
        cmd.mul_frame = 1'b1;
        state_nxt = S_PM1;
      end
      S_PM1: begin
        cmd.mul_lo = 1'b1;
        state_nxt = S_PM2;
      end
      S_PM2: begin
        cmd.mul_hi = 1'b1;
        cnt_nxt = '0;
        state_nxt = S_PDIV;
      end
      S_PDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_end ? 6'd0 : cnt_r + 6'd1;
        if (cnt_end) begin
          state_nxt = S_VCHK;
        end
      end
      S_VCHK: begin
        cnt_nxt = '0;
        if (stat.vor_ok) begin
          cmd.vor_load = 1'b1;
          state_nxt = S_VDIV;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_VDIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt = cnt_end ? 6'd0 : cnt_r + 6'd1;
        if (cnt_end) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.clear = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  a_last_starts_calc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) |=> (state_r == S_PM0))
    else $error("final byte did not start the duration computation");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < 6'(DIV_STEPS))
    else $error("divide step counter out of range");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded over an untaken result");

  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (state_r == S_PDIV || state_r == S_VDIV))
    else $error("divide step outside a divide state");

endmodule

FILE: design/whdp_dp.sv
// Datapath of the RIFF/WAVE header duration parser.
// Chunk walk registers, duration multiplies, restoring divider and result register.
// Depends on whdp_pkg.
`timescale 1ns / 1ps
module whdp_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  whdp_pkg::whdp_in_t   in_data,
  input  whdp_pkg::whdp_cmd_t  cmd,
  output whdp_pkg::whdp_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output whdp_pkg::whdp_out_t  out_data
);
  import whdp_pkg::*;

  // Walk state.
  logic [4:0]  pos_r, pos_nxt;
  logic [2:0]  hk_r, hk_nxt;
  logic [63:0] hdr_r, hdr_nxt;
  logic [31:0] size_r, size_nxt;
  logic [31:0] idx_r, idx_nxt;
  logic        bad_r, bad_nxt;
  logic        in_dat_r, in_dat_nxt;
  logic        is_fmt_r, is_fmt_nxt;
  logic        is_dat_r, is_dat_nxt;
  logic        tag_fnd_r, tag_fnd_nxt;
  logic        vor_fnd_r, vor_fnd_nxt;
  logic        pad_r, pad_nxt;
  logic [15:0] first_tag_r, first_tag_nxt;
  logic [63:0] pend_lo_r, pend_lo_nxt;
  logic [15:0] pend_bits_r, pend_bits_nxt;
  logic [31:0] pend_cnt_r, pend_cnt_nxt;
  logic [63:0] pcm_lo_r, pcm_lo_nxt;
  logic [15:0] pcm_bits_r, pcm_bits_nxt;
  logic [63:0] vor_lo_r, vor_lo_nxt;
  logic [31:0] vor_cnt_r, vor_cnt_nxt;
  logic [31:0] dsz_r, dsz_nxt;

  // Duration arithmetic.
  logic [28:0] frame_r;
  logic [44:0] den_lo_r;
  logic [60:0] den_r;
  logic [61:0] rem_r;
  logic [41:0] qn_r;
  logic        vor_used_r;
  logic        out_valid_r;
  whdp_out_t   out_r;

  logic        finish;
  logic [31:0] fsz;
  logic        walk_ok, is_pcm, pcm_ok;
  logic [15:0] ptag, pch, vtag, vch;
  logic [31:0] prate, vrate;
  logic [44:0] den_hi;
  logic [61:0] trial;
  logic        take;

  always_comb begin
    pos_nxt = pos_r; hk_nxt = hk_r; hdr_nxt = hdr_r; size_nxt = size_r; idx_nxt = idx_r;
    bad_nxt = bad_r; in_dat_nxt = in_dat_r; is_fmt_nxt = is_fmt_r; is_dat_nxt = is_dat_r;
    tag_fnd_nxt = tag_fnd_r; vor_fnd_nxt = vor_fnd_r; pad_nxt = pad_r;
    first_tag_nxt = first_tag_r; pend_lo_nxt = pend_lo_r; pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt = pend_cnt_r; pcm_lo_nxt = pcm_lo_r; pcm_bits_nxt = pcm_bits_r;
    vor_lo_nxt = vor_lo_r; vor_cnt_nxt = vor_cnt_r; dsz_nxt = dsz_r;
    finish = 1'b0;
    fsz = size_r;
    if (cmd.accept) begin
      if (pos_r != MIN_FILE_SIZE) begin
        pos_nxt = pos_r + 5'd1;
      end
      if (pos_r < 5'd12) begin
        if (pos_r < 5'd4 && in_data.data_byte != riff_mark(pos_r[1:0])) begin
          bad_nxt = 1'b1;
        end
        if (pos_r >= 5'd8 && in_data.data_byte != wave_mark(pos_r[1:0])) begin
          bad_nxt = 1'b1;
        end
      end else if (!bad_r) begin
        if (in_dat_r) begin
          if (is_fmt_r) begin
            if (idx_r < 32'd8) begin
              pend_lo_nxt[idx_r[2:0]*8 +: 8] = in_data.data_byte;
            end else if (idx_r == 32'd14) begin
              pend_bits_nxt[7:0] = in_data.data_byte;
            end else if (idx_r == 32'd15) begin
              pend_bits_nxt[15:8] = in_data.data_byte;
            end else if (idx_r >= 32'd24 && idx_r <= 32'd27) begin
              pend_cnt_nxt[idx_r[1:0]*8 +: 8] = in_data.data_byte;
            end
          end
          idx_nxt = idx_r + 32'd1;
          if (idx_nxt == size_r) begin
            finish = 1'b1;
          end
        end else if (pad_r) begin
          pad_nxt = 1'b0;
        end else begin
          hdr_nxt = {in_data.data_byte, hdr_r[63:8]};
          hk_nxt = hk_r + 3'd1;
          if (hk_r == 3'd7) begin
            size_nxt = hdr_nxt[63:32];
            fsz = hdr_nxt[63:32];
            is_fmt_nxt = (hdr_nxt[31:0] == ID_FMT);
            is_dat_nxt = (hdr_nxt[31:0] == ID_DATA);
            pend_lo_nxt = '0;
            pend_bits_nxt = '0;
            pend_cnt_nxt = '0;
            in_dat_nxt = 1'b1;
            idx_nxt = '0;
            finish = (hdr_nxt[63:32] == 32'd0);
          end
        end
      end
      if (finish) begin
        if (is_fmt_nxt) begin
          if (!tag_fnd_r && fsz >= 32'd2) begin
            first_tag_nxt = pend_lo_nxt[15:0];
            tag_fnd_nxt = 1'b1;
          end
          if (fsz >= 32'd16) begin
            pcm_lo_nxt = pend_lo_nxt;
            pcm_bits_nxt = pend_bits_nxt;
          end
          if (!vor_fnd_r && fsz >= VOR_MIN_SIZE) begin
            vor_lo_nxt = pend_lo_nxt;
            vor_cnt_nxt = pend_cnt_nxt;
            vor_fnd_nxt = 1'b1;
          end
        end else if (is_dat_nxt) begin
          dsz_nxt = fsz;
        end
        pad_nxt = fsz[0];
        in_dat_nxt = 1'b0;
        is_fmt_nxt = 1'b0;
        is_dat_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      pos_r <= '0; hk_r <= '0; hdr_r <= '0; size_r <= '0; idx_r <= '0;
      bad_r <= 1'b0; in_dat_r <= 1'b0; is_fmt_r <= 1'b0; is_dat_r <= 1'b0;
      tag_fnd_r <= 1'b0; vor_fnd_r <= 1'b0; pad_r <= 1'b0;
      first_tag_r <= '0; pend_lo_r <= '0; pend_bits_r <= '0; pend_cnt_r <= '0;
      pcm_lo_r <= '0; pcm_bits_r <= '0; vor_lo_r <= '0; vor_cnt_r <= '0; dsz_r <= '0;
    end else begin
      pos_r <= pos_nxt; hk_r <= hk_nxt; hdr_r <= hdr_nxt; size_r <= size_nxt;
      idx_r <= idx_nxt; bad_r <= bad_nxt; in_dat_r <= in_dat_nxt;
      is_fmt_r <= is_fmt_nxt; is_dat_r <= is_dat_nxt;
      tag_fnd_r <= tag_fnd_nxt; vor_fnd_r <= vor_fnd_nxt; pad_r <= pad_nxt;
      first_tag_r <= first_tag_nxt; pend_lo_r <= pend_lo_nxt;
      pend_bits_r <= pend_bits_nxt; pend_cnt_r <= pend_cnt_nxt;
      pcm_lo_r <= pcm_lo_nxt; pcm_bits_r <= pcm_bits_nxt;
      vor_lo_r <= vor_lo_nxt; vor_cnt_r <= vor_cnt_nxt; dsz_r <= dsz_nxt;
    end
  end

  assign ptag  = pcm_lo_r[15:0];
  assign pch   = pcm_lo_r[31:16];
  assign prate = pcm_lo_r[63:32];
  assign vtag  = vor_lo_r[15:0];
  assign vch   = vor_lo_r[31:16];
  assign vrate = vor_lo_r[63:32];

  assign walk_ok = !bad_r && (pos_r == MIN_FILE_SIZE) && !in_dat_r;
  assign is_pcm  = (first_tag_r == TAG_PCM) || (first_tag_r == TAG_EXT);
  assign pcm_ok  = walk_ok && ((ptag == TAG_PCM) || (ptag == TAG_EXT)) && (dsz_r != '0)
                   && (pch != '0) && (prate != '0) && (pcm_bits_r != '0)
                   && (pcm_bits_r[2:0] == 3'd0);

  // The fallback only applies when the PCM quotient came out zero.
  assign stat.vor_ok = (qn_r == '0) && !is_pcm && vor_fnd_r && (vtag == TAG_VOR)
                       && (vch != '0) && (vrate != '0) && (vor_cnt_r != '0);
  assign stat.out_free = !out_valid_r || !out_stall;

  assign den_hi = 45'(frame_r) * 45'(prate[31:16]);
  assign trial  = {rem_r[60:0], qn_r[41]};
  assign take   = (trial >= 62'(den_r));

  always_ff @(posedge clk) begin
    if (cmd.mul_frame) begin
      frame_r <= 29'(pch) * 29'(pcm_bits_r[15:3]);
      qn_r <= pcm_ok ? 42'(dsz_r) * MS_PER_SEC : '0;
      rem_r <= '0;
    end else if (cmd.vor_load) begin
      qn_r <= 42'(vor_cnt_r) * MS_PER_SEC;
      den_r <= 61'(vrate);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= take ? trial - 62'(den_r) : trial;
      qn_r <= {qn_r[40:0], take};
    end
    if (cmd.mul_lo) begin
      den_lo_r <= 45'(frame_r) * 45'(prate[15:0]);
    end
    if (cmd.mul_hi) begin
      den_r <= pcm_ok ? 61'(den_lo_r) + (61'(den_hi) << 16) : 61'd1;
    end
    if (cmd.out_load) begin
      out_r.is_pcm <= is_pcm;
      out_r.duration_ms <= qn_r;
      out_r.sample_bits <= pcm_bits_r;
      if (vor_used_r && qn_r != '0) begin
        out_r.channel_count <= vch;
        out_r.sample_rate <= vrate;
      end else begin
        out_r.channel_count <= pch;
        out_r.sample_rate <= prate;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vor_used_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.mul_frame) begin
        vor_used_r <= 1'b0;
      end else if (cmd.vor_load) begin
        vor_used_r <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: design/wave_header_duration_parser.sv
// RIFF/WAVE header duration parser, top level.
// Byte input channel, one result per file, no configuration registers.
// Sequence:
//   File bytes are taken one per cycle while the block walks the chunks.
//   The request that carries last_byte starts the duration computation:
//   the frame, low and high multiplies, a restoring divide, a check and,
//   when the Vorbis fallback applies, a second restoring divide.
//   in_stall is high once the final byte is taken until the result is loaded.
// Reset (rst_n low, synchronous) returns the walk to the start of a file
// and drops out_valid. After each result the walk restarts by itself.
// When the receiver holds out_stall, the result stays on out_data; a further
// result that is ready to load waits, with in_stall high, until the first is taken;
// bytes of the next file are accepted while a result waits.
// Depends on whdp_pkg, whdp_ctrl and whdp_dp.
`timescale 1ns / 1ps
module wave_header_duration_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  whdp_pkg::whdp_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output whdp_pkg::whdp_out_t out_data
);
  import whdp_pkg::*;

  whdp_cmd_t  cmd;
  whdp_stat_t stat;

  whdp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_data.last_byte),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  whdp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
